// File: design/aca_pkg.sv
// Shared constants, codes and control types for the ADC current averager.
// Used by the controller, datapath and top level.
package aca_pkg;

  localparam int PAIRS     = 16;
  localparam int PIDX_W    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int DATA_W    = 16;
  localparam int SUM_W     = DATA_W + $clog2(PAIRS);
  localparam int RSUM_W    = 32;
  localparam int CNT_W     = 16;
  localparam int CAL_W     = 5;
  localparam int DIV_STEPS = RSUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int CFG_AW    = 2;
  localparam int CFG_DW    = 32;

  localparam logic [CAL_W-1:0]  CALIB_READS_RST  = CAL_W'(17);
  localparam logic [CFG_AW-1:0] ADDR_CALIB_READS = CFG_AW'(0);
  localparam logic [CNT_W-1:0]  COUNT_MAX        = '1;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } aca_state_t;

  typedef struct packed {
    logic sample_en;
    logic read_start;
    logic div_step;
    logic finish;
  } aca_cmd_t;

  typedef struct packed {
    logic count_zero;
  } aca_sts_t;

endpackage

// File: design/aca_if.sv
// Valid/ready channel interfaces for sample/read items and result items.
// Standalone; widths follow the fixed field widths.
interface aca_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] current_sample;
  logic [15:0] vbus_sample;
  logic        motor_enabled;

  modport source (output valid, action, current_sample, vbus_sample, motor_enabled,
                  input ready);
  modport sink   (input valid, action, current_sample, vbus_sample, motor_enabled,
                  output ready);
endinterface

interface aca_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] current_counts;
  logic [15:0] vbus_mean;
  logic        no_data;

  modport source (output valid, current_counts, vbus_mean, no_data, input ready);
  modport sink   (input valid, current_counts, vbus_mean, no_data, output ready);
endinterface

// File: design/aca_ctrl.sv
// Controller: accepts items, sequences the serial divide and loads the result.
// Depends on aca_pkg for the state enum and command/status structs.
module aca_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_action,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  aca_pkg::aca_sts_t  sts,
  output aca_pkg::aca_cmd_t  cmd
);
  import aca_pkg::*;

  aca_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_ready  = 1'b0;
    accept    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        accept   = in_valid;
        if (accept && in_action == ACT_SAMPLE) begin
          cmd.sample_en = 1'b1;
        end else if (accept && in_action == ACT_READ) begin
          cmd.read_start = 1'b1;
          step_nxt       = '0;
          state_nxt      = sts.count_zero ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // wait for the output slot to be free
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_zero_skips_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.read_start && sts.count_zero |=> state_r == ST_FIN)
    else $error("empty read did not skip the divide");
  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV && step_r == STEP_W'(DIV_STEPS - 1) |=> state_r == ST_FIN)
    else $error("divide did not end after its last step");
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("result load did not raise out valid");
`endif
endmodule

// File: design/aca_dp.sv
// Datapath: block sums, running sum/count, serial divider, offset and result.
// Depends on aca_pkg for widths, constants and command/status structs.
module aca_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  aca_pkg::aca_cmd_t            cmd,
  output aca_pkg::aca_sts_t            sts,
  input  logic [aca_pkg::DATA_W-1:0]   in_current_sample,
  input  logic [aca_pkg::DATA_W-1:0]   in_vbus_sample,
  input  logic                         in_motor_enabled,
  input  logic [aca_pkg::CAL_W-1:0]    calib_reads,
  output logic [aca_pkg::DATA_W-1:0]   out_current_counts,
  output logic [aca_pkg::DATA_W-1:0]   out_vbus_mean,
  output logic                         out_no_data
);
  import aca_pkg::*;

  logic [SUM_W-1:0]  blk_cur_r, blk_cur_nxt;
  logic [SUM_W-1:0]  blk_vbus_r, blk_vbus_nxt;
  logic [PIDX_W-1:0] pair_idx_r, pair_idx_nxt;
  logic [RSUM_W-1:0] run_sum_r, run_sum_nxt;
  logic [CNT_W-1:0]  run_cnt_r, run_cnt_nxt;
  logic [DATA_W-1:0] vbus_avg_r, vbus_avg_nxt;
  logic [DATA_W-1:0] offset_r, offset_nxt;
  logic [CAL_W-1:0]  calib_done_r, calib_done_nxt;

  logic [RSUM_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  divisor_r, divisor_nxt;
  logic              nodata_r, nodata_nxt;
  logic              motor_r, motor_nxt;

  logic [DATA_W-1:0] cur_r, cur_nxt;
  logic [DATA_W-1:0] vmean_r, vmean_nxt;
  logic              nd_r, nd_nxt;

  logic [SUM_W-1:0]  cur_sum, vbus_sum;
  logic [CNT_W:0]    rem_sh;
  logic              ge;
  logic [DATA_W-1:0] mean, off_eff;
  logic              do_cal;

  assign sts.count_zero = (run_cnt_r == '0);

  assign cur_sum  = blk_cur_r + SUM_W'(in_current_sample);
  assign vbus_sum = blk_vbus_r + SUM_W'(in_vbus_sample);

  // one restoring divide step per cycle
  assign rem_sh = {rem_r, quo_r[RSUM_W-1]};
  assign ge     = rem_sh >= {1'b0, divisor_r};

  assign mean    = quo_r[DATA_W-1:0];
  assign do_cal  = (calib_done_r < calib_reads) && !motor_r;
  assign off_eff = do_cal ? mean : offset_r;

  always_comb begin
    blk_cur_nxt    = blk_cur_r;
    blk_vbus_nxt   = blk_vbus_r;
    pair_idx_nxt   = pair_idx_r;
    run_sum_nxt    = run_sum_r;
    run_cnt_nxt    = run_cnt_r;
    vbus_avg_nxt   = vbus_avg_r;
    offset_nxt     = offset_r;
    calib_done_nxt = calib_done_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    divisor_nxt    = divisor_r;
    nodata_nxt     = nodata_r;
    motor_nxt      = motor_r;
    cur_nxt        = cur_r;
    vmean_nxt      = vmean_r;
    nd_nxt         = nd_r;

    if (cmd.sample_en) begin
      if (pair_idx_r == PIDX_W'(PAIRS - 1)) begin
        // close the block
        if (run_cnt_r != COUNT_MAX) begin
          run_sum_nxt = run_sum_r + RSUM_W'(cur_sum / SUM_W'(PAIRS));
          run_cnt_nxt = run_cnt_r + CNT_W'(1);
        end
        vbus_avg_nxt = DATA_W'(vbus_sum / SUM_W'(PAIRS));
        blk_cur_nxt  = '0;
        blk_vbus_nxt = '0;
        pair_idx_nxt = '0;
      end else begin
        blk_cur_nxt  = cur_sum;
        blk_vbus_nxt = vbus_sum;
        pair_idx_nxt = pair_idx_r + PIDX_W'(1);
      end
    end

    if (cmd.read_start) begin
      quo_nxt     = run_sum_r;
      rem_nxt     = '0;
      divisor_nxt = run_cnt_r;
      nodata_nxt  = sts.count_zero;
      motor_nxt   = in_motor_enabled;
      run_sum_nxt = '0;
      run_cnt_nxt = '0;
    end

    if (cmd.div_step) begin
      rem_nxt = ge ? CNT_W'(rem_sh - {1'b0, divisor_r}) : rem_sh[CNT_W-1:0];
      quo_nxt = {quo_r[RSUM_W-2:0], ge};
    end

    if (cmd.finish) begin
      vmean_nxt = vbus_avg_r;
      nd_nxt    = nodata_r;
      if (nodata_r) begin
        cur_nxt = '0;
      end else begin
        if (do_cal) begin
          offset_nxt     = mean;
          calib_done_nxt = calib_done_r + CAL_W'(1);
        end
        cur_nxt = (mean >= off_eff) ? (mean - off_eff) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_cur_r    <= '0;
      blk_vbus_r   <= '0;
      pair_idx_r   <= '0;
      run_sum_r    <= '0;
      run_cnt_r    <= '0;
      vbus_avg_r   <= '0;
      offset_r     <= '0;
      calib_done_r <= '0;
    end else begin
      blk_cur_r    <= blk_cur_nxt;
      blk_vbus_r   <= blk_vbus_nxt;
      pair_idx_r   <= pair_idx_nxt;
      run_sum_r    <= run_sum_nxt;
      run_cnt_r    <= run_cnt_nxt;
      vbus_avg_r   <= vbus_avg_nxt;
      offset_r     <= offset_nxt;
      calib_done_r <= calib_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
    nodata_r  <= nodata_nxt;
    motor_r   <= motor_nxt;
    cur_r     <= cur_nxt;
    vmean_r   <= vmean_nxt;
    nd_r      <= nd_nxt;
  end

  assign out_current_counts = cur_r;
  assign out_vbus_mean      = vmean_r;
  assign out_no_data        = nd_r;

`ifndef NO_ASSERTIONS
  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.read_start |=> run_sum_r == '0 && run_cnt_r == '0)
    else $error("read did not clear the running sum and count");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> rem_r < divisor_r)
    else $error("divider remainder out of range");
  a_nodata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && nodata_r |=> cur_r == '0 && nd_r)
    else $error("empty read gave a non-zero current");
`endif
endmodule

// File: design/adc_current_averager_with_offset_cal.sv
// Sample-pair item: a new item every cycle while idle.
// Read item: accept, 32 steps of the one-bit-per-cycle restoring divider, then
// result load; the divider steps are skipped when no block was completed.
// A finished result waits in the output register; sample items go on meanwhile.
// Reset (rst_n low, synchronous) clears all sums, counts, offset and
// calibration progress, and sets calib_reads to 17.
module adc_current_averager_with_offset_cal (
  input  logic                          clk,
  input  logic                          rst_n,
  aca_in_if.sink                        in_ch,
  aca_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [aca_pkg::CFG_AW-1:0]    paddr,
  input  logic [aca_pkg::CFG_DW-1:0]    pwdata,
  output logic [aca_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);
  import aca_pkg::*;

  logic [CAL_W-1:0] calib_reads_r, calib_reads_nxt;
  logic             cfg_wr;
  aca_cmd_t         cmd;
  aca_sts_t         sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    calib_reads_nxt = calib_reads_r;
    if (cfg_wr && paddr == ADDR_CALIB_READS) begin
      calib_reads_nxt = pwdata[CAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_reads_r <= CALIB_READS_RST;
    end else begin
      calib_reads_r <= calib_reads_nxt;
    end
  end

  assign prdata = (paddr == ADDR_CALIB_READS) ? CFG_DW'(calib_reads_r) : '0;

  aca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  aca_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_current_sample  (in_ch.current_sample),
    .in_vbus_sample     (in_ch.vbus_sample),
    .in_motor_enabled   (in_ch.motor_enabled),
    .calib_reads        (calib_reads_r),
    .out_current_counts (out_ch.current_counts),
    .out_vbus_mean      (out_ch.vbus_mean),
    .out_no_data        (out_ch.no_data)
  );

endmodule
